### hw/rtl/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants for the text display filter.
// ----------------------------------------------------------------------------
package tdf_pkg;

   // line number digits and derived widths
   localparam int NUMBER_DIGITS = 6;
   localparam int TAIL_MAX      = 4;
   localparam int SEQ_MAX       = NUMBER_DIGITS + 1 + TAIL_MAX;
   localparam int SEQ_W         = $clog2(SEQ_MAX);
   localparam int TAIL_W        = $clog2(TAIL_MAX);

   // request queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUMBER_NONBLANK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUMBER_ALL       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SQUEEZE_BLANK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOW_NONPRINTING = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOW_ENDS        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOW_TABS        = 3'd5;

   // character codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
   localparam logic [7:0] CH_HIGH_MIN = 8'h80;
   localparam logic [7:0] CH_META_MAX = 8'h9F;
   localparam logic [7:0] CH_ALL_ONES = 8'hFF;
   localparam logic [7:0] CARET_OFFSET = 8'h40;
   localparam logic [7:0] META_OFFSET  = 8'h80;

   // option settings
   typedef struct packed {
      logic number_nonblank;
      logic number_all;
      logic squeeze_blank;
      logic show_nonprinting;
      logic show_ends;
      logic show_tabs;
   } tdf_cfg_type;

   // one queued request: optional number prefix plus up to four tail bytes
   typedef struct packed {
      logic                           num_en;
      logic [NUMBER_DIGITS-1:0][3:0]  bcd;
      logic [TAIL_MAX-1:0][7:0]       tail;
      logic [TAIL_W-1:0]              tail_last;
   } tdf_entry_type;

endpackage

### hw/rtl/tdf_front.sv
// ----------------------------------------------------------------------------
// tdf_front
// Accepts requests, applies squeeze, keeps the line state and counter,
// and builds the byte plan for each request.
// ----------------------------------------------------------------------------
module tdf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  tdf_pkg::tdf_cfg_type  cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   input  logic                  q_full,
   output logic                  q_push,
   output tdf_pkg::tdf_entry_type q_entry
);
   import tdf_pkg::*;

   logic                          last_nl_ff, last_nl_in;
   logic                          blank_ff, blank_in;
   logic [NUMBER_DIGITS-1:0][3:0] line_ff, line_in;
   logic [NUMBER_DIGITS-1:0][3:0] line_inc;
   logic                          accept, nl, drop, do_num, record, carry, all_nine;
   logic [7:0]                    c;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign c         = req_in_byte;
   assign nl        = (c == CH_NL);
   assign drop      = cfg.squeeze_blank && nl && last_nl_ff && blank_ff;
   assign do_num    = last_nl_ff &&
                      ((cfg.number_nonblank && !nl) ||
                       (!cfg.number_nonblank && cfg.number_all));
   assign record    = !(cfg.show_tabs && c == CH_TAB) &&
                      !(cfg.show_nonprinting && c == CH_ALL_ONES);

   // saturating decimal increment of the line counter
   always_comb begin
      carry    = 1'b1;
      all_nine = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (line_ff[i] != 4'd9) all_nine = 1'b0;
         if (carry) begin
            if (line_ff[i] == 4'd9) begin
               line_inc[i] = 4'd0;
            end else begin
               line_inc[i] = line_ff[i] + 4'd1;
               carry       = 1'b0;
            end
         end else begin
            line_inc[i] = line_ff[i];
         end
      end
      if (all_nine) line_inc = line_ff;
   end

   // next state
   always_comb begin
      last_nl_in = last_nl_ff;
      blank_in   = blank_ff;
      line_in    = line_ff;
      if (accept && !drop) begin
         if (cfg.squeeze_blank) blank_in = nl && last_nl_ff;
         if (do_num) line_in = line_inc;
         if (record) last_nl_in = nl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_nl_ff <= 1'b1;
         blank_ff   <= 1'b0;
         line_ff    <= '0;
      end else begin
         last_nl_ff <= last_nl_in;
         blank_ff   <= blank_in;
         line_ff    <= line_in;
      end
   end

   // byte plan for the back end
   always_comb begin
      q_entry           = '0;
      q_entry.num_en    = do_num;
      q_entry.bcd       = line_inc;
      q_entry.tail[0]   = c;
      q_entry.tail_last = TAIL_W'(0);
      if (cfg.show_tabs && c == CH_TAB) begin
         q_entry.tail[0]   = CH_CARET;
         q_entry.tail[1]   = CH_I;
         q_entry.tail_last = TAIL_W'(1);
      end else if (cfg.show_nonprinting && c != CH_NL && c != CH_TAB) begin
         if (c <= CH_CTRL_MAX || c == CH_DEL) begin
            // control byte or delete: caret form
            q_entry.tail[0]   = CH_CARET;
            q_entry.tail[1]   = c ^ CARET_OFFSET;
            q_entry.tail_last = TAIL_W'(1);
         end else if (c >= CH_HIGH_MIN && c <= CH_META_MAX) begin
            q_entry.tail[0]   = CH_M;
            q_entry.tail[1]   = CH_DASH;
            q_entry.tail[2]   = CH_CARET;
            q_entry.tail[3]   = c - CARET_OFFSET;
            q_entry.tail_last = TAIL_W'(3);
         end else if (c == CH_ALL_ONES) begin
            q_entry.tail[0]   = CH_M;
            q_entry.tail[1]   = CH_DASH;
            q_entry.tail[2]   = CH_CARET;
            q_entry.tail[3]   = CH_QMARK;
            q_entry.tail_last = TAIL_W'(3);
         end else if (c >= CH_HIGH_MIN) begin
            q_entry.tail[0]   = CH_M;
            q_entry.tail[1]   = CH_DASH;
            q_entry.tail[2]   = c - META_OFFSET;
            q_entry.tail_last = TAIL_W'(2);
         end
      end else if (cfg.show_ends && nl) begin
         q_entry.tail[0]   = CH_DOLLAR;
         q_entry.tail[1]   = CH_NL;
         q_entry.tail_last = TAIL_W'(1);
      end
   end

   assign q_push = accept && !drop;

endmodule

### hw/rtl/tdf_queue.sv
// ----------------------------------------------------------------------------
// tdf_queue
// Short first-in first-out queue of byte plans between front and back.
// ----------------------------------------------------------------------------
module tdf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tdf_pkg::tdf_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output tdf_pkg::tdf_entry_type head_entry
);
   import tdf_pkg::*;

   tdf_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      if (pop)  rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

### hw/rtl/tdf_back.sv
// ----------------------------------------------------------------------------
// tdf_back
// Walks each byte plan into the response register, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module tdf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  tdf_pkg::tdf_entry_type head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_of_run
);
   import tdf_pkg::*;

   logic [SEQ_W-1:0]         pos_ff, pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               byte_ff, byte_in;
   logic                     last_ff, last_in;
   logic                     load, step, at_last;
   logic [SEQ_W-1:0]         last_pos, tail_pos;
   logic [TAIL_W-1:0]        tail_idx;
   logic [NUMBER_DIGITS-1:0] zero_above;
   logic [7:0]               cur_byte;

   assign load = !rsp_valid_ff || !rsp_stall;
   assign step = load && head_valid;

   // last position of this plan
   assign last_pos = head_entry.num_en ?
                     SEQ_W'(NUMBER_DIGITS + 1) + SEQ_W'(head_entry.tail_last) :
                     SEQ_W'(head_entry.tail_last);
   assign at_last  = (pos_ff == last_pos);
   assign pop      = step && at_last;

   assign tail_pos = head_entry.num_en ? pos_ff - SEQ_W'(NUMBER_DIGITS + 1) : pos_ff;
   assign tail_idx = tail_pos[TAIL_W-1:0];

   // leading zero digits print as spaces, the units digit always prints
   always_comb begin
      zero_above[NUMBER_DIGITS-1] = (head_entry.bcd[NUMBER_DIGITS-1] == 4'd0);
      for (int j = NUMBER_DIGITS - 2; j >= 0; j--) begin
         zero_above[j] = zero_above[j+1] && (head_entry.bcd[j] == 4'd0);
      end
   end

   // byte at the current position
   always_comb begin
      cur_byte = head_entry.tail[tail_idx];
      if (head_entry.num_en) begin
         if (pos_ff == SEQ_W'(NUMBER_DIGITS)) cur_byte = CH_TAB;
         for (int p = 0; p < NUMBER_DIGITS; p++) begin
            if (pos_ff == SEQ_W'(p)) begin
               if (zero_above[NUMBER_DIGITS-1-p] && p != NUMBER_DIGITS - 1) begin
                  cur_byte = CH_SPACE;
               end else begin
                  cur_byte = CH_ZERO | {4'd0, head_entry.bcd[NUMBER_DIGITS-1-p]};
               end
            end
         end
      end
   end

   // position counter and response register
   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         byte_in      = cur_byte;
         last_in      = at_last;
      end
      if (step) pos_in = at_last ? '0 : pos_ff + SEQ_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

### hw/rtl/text_display_filter_unit.sv
// ----------------------------------------------------------------------------
// text_display_filter_unit
// Byte stream display filter: squeeze, line numbering, tab, non-printing
// and end-of-line display, one output byte per cycle while not stalled.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_in_byte
//   rsp       out        rsp_valid/rsp_stall   rsp_out_byte, rsp_last_of_run
//   csr       in         csr_write_enable      csr_index, csr_write_data
//
// The back end emits one byte per cycle while rsp_stall is low; a request
// produces 1 to NUMBER_DIGITS + 5 (11) bytes, typically 1.
// The front end takes one request per cycle until the four-entry queue
// fills; a squeezed newline is accepted but produces nothing.
// Synchronous reset clears options, counter and queue, and sets the line state to start of line.
// rsp_stall holds the response register; the front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module text_display_filter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_in_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_last_of_run,
   input  logic                              csr_write_enable,
   input  logic [tdf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tdf_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import tdf_pkg::*;

   tdf_cfg_type   cfg_ff, cfg_in;
   tdf_entry_type push_entry, head_entry;
   logic          q_push, q_full, q_pop, head_valid;

   // option registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_NUMBER_NONBLANK:  cfg_in.number_nonblank  = csr_write_data[0];
            CSR_NUMBER_ALL:       cfg_in.number_all       = csr_write_data[0];
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_write_data[0];
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_write_data[0];
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_write_data[0];
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_write_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   tdf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   // request queue
   tdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // back end
   tdf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
